// ===== hw/rtl/bgde_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery gauge display encoder package
// Shared constants, display types and the seven-segment digit table.
// ----------------------------------------------------------------------------
package bgde_pkg;

	// Scaling constants.
	localparam int unsigned MvScale    = 5000;   // millivolts per full scale, over 1024
	localparam int unsigned TenthsMul  = 15729;  // 3 * 5243, so x * 3 / 25 = (x * TenthsMul) >> 17
	localparam int unsigned PctLow     = 320;
	localparam int unsigned PctHigh    = 584;
	localparam int unsigned PctRecip   = 31776;  // 2^23 / 264, rounded up
	localparam int unsigned Div100Mul  = 41;     // x / 100 = (x * 41) >> 12 for x < 1000
	localparam int unsigned Div10Mul   = 205;    // x / 10 = (x * 205) >> 11 for x < 1000

	// Segment bits.
	localparam logic [7:0] SegDp    = 8'h80;
	localparam logic [7:0] SegBlank = 8'h00;

	// Register indexes of the configuration port.
	typedef enum logic [1:0] {
		CFG_SHOW_VOLTAGE = 2'd0,
		CFG_TEST_ENABLE  = 2'd1,
		CFG_TEST_VALUE   = 2'd2
	} cfg_index_t;

	// Voltage digits as they travel down the pipeline.
	typedef struct packed {
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] ones;
		logic       ge100;
		logic       ge10;
	} volt_dig_t;

	// Everything the display encoder hands back to the output register.
	typedef struct packed {
		logic [7:0] pct_h;
		logic [7:0] pct_t;
		logic [7:0] pct_o;
		logic [1:0] bar_upper;
		logic [7:0] bar_lower;
		logic       low_blink;
		logic [7:0] volt_h;
		logic [7:0] volt_t;
		logic [7:0] volt_o;
	} disp_t;

	// Seven-segment code of one decimal digit, gfedcba in bits 6..0.
	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0:    s = 8'h3f;
			4'd1:    s = 8'h06;
			4'd2:    s = 8'h5b;
			4'd3:    s = 8'h4f;
			4'd4:    s = 8'h66;
			4'd5:    s = 8'h6d;
			4'd6:    s = 8'h7d;
			4'd7:    s = 8'h07;
			4'd8:    s = 8'h7f;
			4'd9:    s = 8'h6f;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

// ===== hw/rtl/bgde_seg_encode.sv =====
// ----------------------------------------------------------------------------
// Battery gauge display segment encoder
// Turns the final percent and the voltage digits into segment bytes,
// the bar pattern and the low-charge blink flag.
// ----------------------------------------------------------------------------
module bgde_seg_encode (
	input  logic [6:0]          percent,
	input  logic [3:0]          pct_q10,
	input  bgde_pkg::volt_dig_t volt,
	input  logic                show_voltage,
	output bgde_pkg::disp_t     disp
);
	import bgde_pkg::*;

	logic       pct_ge100;
	logic       pct_ge10;
	logic [3:0] pct_tens;
	logic [6:0] pct_ones_w;
	logic [3:0] pct_ones;

	// Split the percent: the quotient by ten comes in precomputed.
	always_comb begin
		pct_ge100  = (percent >= 7'd100);
		pct_ge10   = (percent >= 7'd10);
		pct_tens   = pct_ge100 ? (pct_q10 - 4'd10) : pct_q10;
		pct_ones_w = percent - 7'({pct_q10, 3'b000} + {2'b00, pct_q10, 1'b0});
		pct_ones   = pct_ones_w[3:0];
	end

	// Segment bytes and bar pattern.
	always_comb begin
		disp.pct_h     = pct_ge100 ? seg_of(4'd1) : SegBlank;
		disp.pct_t     = pct_ge10 ? seg_of(pct_tens) : SegBlank;
		disp.pct_o     = seg_of(pct_ones);
		disp.bar_upper = 2'd0;
		disp.low_blink = 1'b0;
		if (percent == 7'd100) begin
			disp.bar_upper = 2'd3;
			disp.bar_lower = 8'hff;
		end else if (percent inside {[7'd0:7'd10]}) begin
			disp.low_blink = 1'b1;
			disp.bar_lower = 8'h01;
		end else if (percent inside {[7'd11:7'd20]}) begin
			disp.low_blink = 1'b1;
			disp.bar_lower = 8'h03;
		end else if (percent inside {[7'd21:7'd30]}) begin
			disp.bar_lower = 8'h07;
		end else if (percent inside {[7'd31:7'd40]}) begin
			disp.bar_lower = 8'h0f;
		end else if (percent inside {[7'd41:7'd50]}) begin
			disp.bar_lower = 8'h1f;
		end else if (percent inside {[7'd51:7'd60]}) begin
			disp.bar_lower = 8'h3f;
		end else if (percent inside {[7'd61:7'd70]}) begin
			disp.bar_lower = 8'h7f;
		end else if (percent inside {[7'd71:7'd80]}) begin
			disp.bar_lower = 8'hff;
		end else begin
			disp.bar_upper = 2'd1;
			disp.bar_lower = 8'hff;
		end
	end

	// Voltage digits, all zero while the voltage display is off.
	always_comb begin
		if (show_voltage) begin
			disp.volt_h = volt.ge100 ? seg_of(volt.hund) : SegBlank;
			disp.volt_t = (volt.ge10 ? seg_of(volt.tens) : SegBlank) | SegDp;
			disp.volt_o = seg_of(volt.ones);
		end else begin
			disp.volt_h = SegBlank;
			disp.volt_t = SegBlank;
			disp.volt_o = SegBlank;
		end
	end

endmodule

// ===== hw/rtl/battery_gauge_display_encoder.sv =====
// ----------------------------------------------------------------------------
// Battery gauge display encoder
// Scales a 10-bit converter sample of the pack voltage to tenths of a volt
// and a charge percent, and encodes both for a seven-segment display.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: adc_sample with in_valid / in_stall. A transfer happens
//   at a rising edge with in_valid high and in_stall low.
//   Output channel: all result fields with out_valid / out_stall, one
//   result per input sample, in order.
//   Configuration: cfg_we, cfg_index, cfg_data write show_voltage (0),
//   test_enable (1) and test_value (2); other indexes are ignored. Write
//   only while no sample is in flight.
//   A sample passes from the input transfer through five arithmetic
//   stages (millivolts, tenths, percent numerator and voltage quotients,
//   percent and voltage digits, percent quotient) and the output
//   register. Throughput is one sample per cycle while out_stall is low.
//   Reset clears all valid bits and the configuration registers.
//   When the receiver stalls, the output holds and stages fill behind it;
//   in_stall rises only once every stage holds a sample. Nothing is lost
//   or repeated.
// ----------------------------------------------------------------------------
module battery_gauge_display_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [9:0] adc_sample,
	output logic       out_valid,
	input  logic       out_stall,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data,
	output logic [6:0] charge_percent,
	output logic [9:0] pack_tenths,
	output logic [7:0] pct_hundreds_seg,
	output logic [7:0] pct_tens_seg,
	output logic [7:0] pct_ones_seg,
	output logic [1:0] bar_upper,
	output logic [7:0] bar_lower,
	output logic       low_blink,
	output logic [7:0] volt_hundreds_seg,
	output logic [7:0] volt_tens_seg,
	output logic [7:0] volt_ones_seg
);
	import bgde_pkg::*;

	// Configuration registers.
	logic       show_voltage_q;
	logic       test_enable_q;
	logic [6:0] test_value_q;

	// Stage valid bits and advance enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic go1, go2, go3, go4, go5, go6;

	// Stage payloads.
	logic [12:0] mv_s1;
	logic [9:0]  tenths_s2;
	logic [9:0]  tenths_s3;
	logic [14:0] num_s3;
	logic        lo_s3;
	logic        hi_s3;
	logic [2:0]  vh_s3;
	logic [5:0]  vq10_s3;
	logic [9:0]  tenths_s4;
	logic [6:0]  pct_s4;
	volt_dig_t   volt_s4;
	logic [9:0]  tenths_s5;
	logic [6:0]  pct_s5;
	logic [3:0]  pq10_s5;
	volt_dig_t   volt_s5;
	logic [6:0]  pct_q;
	logic [9:0]  tenths_q;
	disp_t       disp_q;

	// Combinational stage results.
	logic [22:0] mv_prod;
	logic [26:0] tenths_prod;
	logic [9:0]  pct_diff;
	logic [15:0] num_prod;
	logic [15:0] vh_prod;
	logic [16:0] vq10_prod;
	logic [29:0] pct_prod;
	logic [6:0]  pct_meas;
	logic [5:0]  vt_w;
	logic [9:0]  vo_w;
	logic [14:0] pq10_prod;
	disp_t       disp_c;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			show_voltage_q <= 1'b0;
			test_enable_q  <= 1'b0;
			test_value_q   <= 7'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SHOW_VOLTAGE: show_voltage_q <= cfg_data[0];
				CFG_TEST_ENABLE:  test_enable_q  <= cfg_data[0];
				CFG_TEST_VALUE:   test_value_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	// A stage advances when it is empty or the stage after it advances.
	always_comb begin
		go6      = !out_valid_q || !out_stall;
		go5      = !v_s5 || go6;
		go4      = !v_s4 || go5;
		go3      = !v_s3 || go4;
		go2      = !v_s2 || go3;
		go1      = !v_s1 || go2;
		in_stall = !go1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (go1) v_s1 <= in_valid;
			if (go2) v_s2 <= v_s1;
			if (go3) v_s3 <= v_s2;
			if (go4) v_s4 <= v_s3;
			if (go5) v_s5 <= v_s4;
			if (go6) out_valid_q <= v_s5;
		end
	end

	// Stage 1: sample to millivolts.
	assign mv_prod = 23'(adc_sample) * 23'(MvScale);

	always_ff @(posedge clk) begin
		if (go1) mv_s1 <= mv_prod[22:10];
	end

	// Stage 2: millivolts to tenths of a volt, mv * 3 / 25 by reciprocal.
	assign tenths_prod = 27'(mv_s1) * 27'(TenthsMul);

	always_ff @(posedge clk) begin
		if (go2) tenths_s2 <= tenths_prod[26:17];
	end

	// Stage 3: percent numerator, clamp flags and voltage quotients.
	always_comb begin
		pct_diff  = tenths_s2 - 10'(PctLow);
		num_prod  = 16'(pct_diff[8:0]) * 16'd100;
		vh_prod   = 16'(tenths_s2) * 16'(Div100Mul);
		vq10_prod = 17'(tenths_s2) * 17'(Div10Mul);
	end

	always_ff @(posedge clk) begin
		if (go3) begin
			tenths_s3 <= tenths_s2;
			num_s3    <= num_prod[14:0];
			lo_s3     <= (tenths_s2 <= 10'(PctLow));
			hi_s3     <= (tenths_s2 >= 10'(PctHigh));
			vh_s3     <= vh_prod[14:12];
			vq10_s3   <= vq10_prod[16:11];
		end
	end

	// Stage 4: percent by reciprocal of 264, test override, voltage digits.
	always_comb begin
		pct_prod = 30'(num_s3) * 30'(PctRecip);
		if (lo_s3) begin
			pct_meas = 7'd0;
		end else if (hi_s3) begin
			pct_meas = 7'd100;
		end else begin
			pct_meas = pct_prod[29:23];
		end
		vt_w = vq10_s3 - 6'({vh_s3, 3'b000} + {2'b00, vh_s3, 1'b0});
		vo_w = tenths_s3 - 10'({vq10_s3, 3'b000} + {3'b000, vq10_s3, 1'b0});
	end

	always_ff @(posedge clk) begin
		if (go4) begin
			tenths_s4     <= tenths_s3;
			pct_s4        <= test_enable_q ? test_value_q : pct_meas;
			volt_s4.hund  <= {1'b0, vh_s3};
			volt_s4.tens  <= vt_w[3:0];
			volt_s4.ones  <= vo_w[3:0];
			volt_s4.ge100 <= (tenths_s3 >= 10'd100);
			volt_s4.ge10  <= (tenths_s3 >= 10'd10);
		end
	end

	// Stage 5: percent quotient by ten.
	assign pq10_prod = 15'(pct_s4) * 15'(Div10Mul);

	always_ff @(posedge clk) begin
		if (go5) begin
			tenths_s5 <= tenths_s4;
			pct_s5    <= pct_s4;
			pq10_s5   <= pq10_prod[14:11];
			volt_s5   <= volt_s4;
		end
	end

	// Stage 6: segment encoding into the output register.
	bgde_seg_encode u_seg_encode (
		.percent      (pct_s5),
		.pct_q10      (pq10_s5),
		.volt         (volt_s5),
		.show_voltage (show_voltage_q),
		.disp         (disp_c)
	);

	always_ff @(posedge clk) begin
		if (go6) begin
			pct_q    <= pct_s5;
			tenths_q <= tenths_s5;
			disp_q   <= disp_c;
		end
	end

	// Output ports.
	assign out_valid         = out_valid_q;
	assign charge_percent    = pct_q;
	assign pack_tenths       = tenths_q;
	assign pct_hundreds_seg  = disp_q.pct_h;
	assign pct_tens_seg      = disp_q.pct_t;
	assign pct_ones_seg      = disp_q.pct_o;
	assign bar_upper         = disp_q.bar_upper;
	assign bar_lower         = disp_q.bar_lower;
	assign low_blink         = disp_q.low_blink;
	assign volt_hundreds_seg = disp_q.volt_h;
	assign volt_tens_seg     = disp_q.volt_t;
	assign volt_ones_seg     = disp_q.volt_o;

endmodule
